[sv/fixed_slot_free_list_allocator_core_defines.svh]
// Assertion macros shared by the checker of the slot allocator core.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, masked during reset
`define FSLA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define FSLA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, checked during reset as well
`define FSLA_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/fsla_pkg.sv]
// Package of the slot allocator core: field widths, codes, command type.
// No dependencies.
`default_nettype none

package fsla_pkg;

   localparam int POOL_SLOTS_DEFAULT = 1024;

   localparam int SLOT_W   = 10;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int CHUNK_W  = 11;

   localparam logic [CHUNK_W-1:0] CHUNK_RESET = 11'd64;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELINK = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OOM      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_NOP,
      OP_ALLOC,
      OP_FREE,
      OP_RELINK
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [SLOT_W-1:0] idx;
   } cmd_type;

endpackage

`default_nettype wire

[sv/fsla_req_if.sv]
// Command channel of the slot allocator core: valid/ready plus command fields.
// Depends on fsla_pkg.
`default_nettype none

interface fsla_req_if;
   logic                          valid;
   logic                          ready;
   logic [fsla_pkg::FUNC_W-1:0]   func;
   logic [fsla_pkg::SLOT_W-1:0]   slot_index;
   logic                          slot_present;

   modport source (output valid, output func, output slot_index, output slot_present,
                   input ready);
   modport sink   (input valid, input func, input slot_index, input slot_present,
                   output ready);
endinterface

`default_nettype wire

[sv/fsla_rsp_if.sv]
// Response channel of the slot allocator core: valid/ready plus result fields.
// Depends on fsla_pkg.
`default_nettype none

interface fsla_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fsla_pkg::SLOT_W-1:0]   slot;
   logic [fsla_pkg::STATUS_W-1:0] status;

   modport source (output valid, output slot, output status, input ready);
   modport sink   (input valid, input slot, input status, output ready);
endinterface

`default_nettype wire

[sv/fsla_front.sv]
// Front end of the slot allocator core: accepts command beats, decodes them
// and holds them in a short queue for the back end. Depends on fsla_pkg, fsla_req_if.
`default_nettype none

module fsla_front (
   input  wire logic              clock,
   input  wire logic              reset,
   fsla_req_if.sink               req_chan,
   output fsla_pkg::cmd_type      cmd_data,
   output logic                   cmd_valid,
   input  wire logic              cmd_ready
);

   fsla_pkg::cmd_type                  queue_ff [fsla_pkg::QUEUE_DEPTH];
   logic [fsla_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [fsla_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [fsla_pkg::QUEUE_CW-1:0]      count_ff, count_in;
   fsla_pkg::cmd_type                  decoded;
   logic                               push;
   logic                               pop;

   always_comb begin
      decoded.idx = req_chan.slot_index;
      unique case (req_chan.func)
         fsla_pkg::FUNC_ALLOC:  decoded.op = fsla_pkg::OP_ALLOC;
         fsla_pkg::FUNC_FREE:   decoded.op = req_chan.slot_present ? fsla_pkg::OP_FREE
                                                                   : fsla_pkg::OP_NOP;
         fsla_pkg::FUNC_RELINK: decoded.op = fsla_pkg::OP_RELINK;
         default:               decoded.op = fsla_pkg::OP_NOP;
      endcase
   end

   assign req_chan.ready = (count_ff != fsla_pkg::QUEUE_CW'(fsla_pkg::QUEUE_DEPTH));
   assign cmd_valid      = (count_ff != '0);
   assign cmd_data       = queue_ff[rd_ptr_ff];
   assign push           = req_chan.valid && req_chan.ready;
   assign pop            = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == fsla_pkg::QUEUE_AW'(fsla_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == fsla_pkg::QUEUE_AW'(fsla_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

[sv/fsla_back.sv]
// Back end of the slot allocator core: free stack, link memory, watermark,
// capacity, chunk register and response register. Depends on fsla_pkg, fsla_rsp_if.
`default_nettype none

module fsla_back #(
   parameter int POOL_SLOTS = fsla_pkg::POOL_SLOTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fsla_pkg::cmd_type             cmd_data,
   input  wire logic                          cmd_valid,
   output logic                               cmd_ready,
   input  wire logic                          csr_we,
   input  wire logic [fsla_pkg::CHUNK_W-1:0]  csr_wdata,
   fsla_rsp_if.source                         rsp_chan
);

   localparam int CNT_W     = $clog2(POOL_SLOTS + 1);
   localparam int MEM_DEPTH = (POOL_SLOTS < (1 << fsla_pkg::SLOT_W))
                              ? POOL_SLOTS : (1 << fsla_pkg::SLOT_W);
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int SUM_W     = ((CNT_W > fsla_pkg::CHUNK_W) ? CNT_W : fsla_pkg::CHUNK_W) + 1;
   localparam int CMP_W     = (CNT_W > fsla_pkg::SLOT_W) ? CNT_W : fsla_pkg::SLOT_W;

   logic [MEM_AW-1:0]             link_mem [MEM_DEPTH];
   logic [MEM_AW-1:0]             rd_ff;

   logic [MEM_AW-1:0]             head_ff, head_in;
   logic                          nonempty_ff, nonempty_in;
   logic [MEM_AW-1:0]             head_link_ff, head_link_in;
   logic                          fill_ff, fill_in;
   logic [CNT_W-1:0]              fresh_ff, fresh_in;
   logic [CNT_W-1:0]              cap_ff, cap_in;
   logic [fsla_pkg::CHUNK_W-1:0]  chunk_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fsla_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [fsla_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                          exec;
   logic                          pop;
   logic                          wr_en;
   logic [MEM_AW-1:0]             wr_addr;
   logic [MEM_AW-1:0]             wr_data;
   logic [MEM_AW-1:0]             head_link;
   logic [MEM_AW-1:0]             free_idx;
   logic [SUM_W-1:0]              grown;

   assign cmd_ready = !rsp_valid_ff || rsp_chan.ready;
   assign exec      = cmd_valid && cmd_ready;
   assign head_link = fill_ff ? rd_ff : head_link_ff;
   assign free_idx  = cmd_data.idx[MEM_AW-1:0];
   assign grown     = SUM_W'(cap_ff) + SUM_W'(chunk_ff);

   always_comb begin
      head_in       = head_ff;
      nonempty_in   = nonempty_ff;
      head_link_in  = head_link;
      fresh_in      = fresh_ff;
      cap_in        = cap_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = free_idx;
      wr_data       = nonempty_ff ? head_ff : free_idx;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      if (exec) begin
         rsp_valid_in  = 1'b1;
         rsp_slot_in   = '0;
         rsp_status_in = fsla_pkg::STATUS_OK;
         unique case (cmd_data.op)
            fsla_pkg::OP_ALLOC: begin
               if (nonempty_ff) begin
                  pop         = 1'b1;
                  rsp_slot_in = fsla_pkg::SLOT_W'(head_ff);
                  if (head_link == head_ff) begin
                     nonempty_in = 1'b0;
                  end else begin
                     head_in = head_link;
                  end
               end else if (fresh_ff >= cap_ff && (chunk_ff == '0 ||
                            grown > SUM_W'(POOL_SLOTS))) begin
                  rsp_status_in = fsla_pkg::STATUS_OOM;
               end else begin
                  if (fresh_ff >= cap_ff) begin
                     cap_in = grown[CNT_W-1:0];
                  end
                  rsp_slot_in = fsla_pkg::SLOT_W'(fresh_ff);
                  fresh_in    = fresh_ff + 1'b1;
               end
            end
            fsla_pkg::OP_FREE: begin
               if (CMP_W'(cmd_data.idx) >= CMP_W'(fresh_ff)) begin
                  rsp_status_in = fsla_pkg::STATUS_BAD_FREE;
               end else begin
                  wr_en        = 1'b1;
                  head_link_in = wr_data;
                  head_in      = free_idx;
                  nonempty_in  = 1'b1;
               end
            end
            fsla_pkg::OP_RELINK: begin
               head_in     = '0;
               nonempty_in = 1'b0;
               fresh_in    = '0;
            end
            fsla_pkg::OP_NOP: begin
               rsp_status_in = fsla_pkg::STATUS_OK;
            end
         endcase
      end
      fill_in = pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         nonempty_ff  <= 1'b0;
         fill_ff      <= 1'b0;
         fresh_ff     <= '0;
         cap_ff       <= '0;
         chunk_ff     <= fsla_pkg::CHUNK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         nonempty_ff  <= nonempty_in;
         fill_ff      <= fill_in;
         fresh_ff     <= fresh_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            chunk_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_link_ff  <= head_link_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (pop) begin
         rd_ff <= link_mem[head_link];
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.slot   = rsp_slot_ff;
   assign rsp_chan.status = rsp_status_ff;

endmodule

`default_nettype wire

[sv/fixed_slot_free_list_allocator_core.sv]
// Slot allocator core: hands out equal-sized pool slots by index from a LIFO
// free stack, takes them back, and grows committed capacity one chunk at a time.
// The core sustains one command per clock while responses are taken: a command
// beat enters a two-deep queue, the back end carries it out from the queue head
// and registers the response beat for the response channel. A pop
// of the free stack reads the link of the new top from the single-port link
// memory into a register that the next command uses, which keeps back-to-back
// allocates at full rate. The link memory needs no clearing pass after reset.
// Depends on fsla_pkg, fsla_req_if, fsla_rsp_if, fsla_front and fsla_back.
`default_nettype none

module fixed_slot_free_list_allocator_core #(
   parameter int POOL_SLOTS = fsla_pkg::POOL_SLOTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   fsla_req_if.sink                           req_chan,
   fsla_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [fsla_pkg::CHUNK_W-1:0]  csr_wdata
);

   fsla_pkg::cmd_type cmd_data;
   logic              cmd_valid;
   logic              cmd_ready;

   fsla_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_data  (cmd_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready)
   );

   fsla_back #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

[sv/fsla_checker.sv]
// Port-level checker of the slot allocator core and its bind to the top level.
// Depends on fsla_pkg and fixed_slot_free_list_allocator_core_defines.svh.
`default_nettype none
`include "fixed_slot_free_list_allocator_core_defines.svh"

module fsla_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [fsla_pkg::SLOT_W-1:0]    rsp_slot,
   input wire logic [fsla_pkg::STATUS_W-1:0]  rsp_status
);

   `FSLA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_slot) && $stable(rsp_status), "response beat dropped or changed while stalled")
   `FSLA_ASSERT_NOW(a_fail_no_slot, rsp_valid && rsp_status != fsla_pkg::STATUS_OK, rsp_slot == '0, "failed command returned a nonzero slot")
   `FSLA_ASSERT_ALWAYS_NEXT(a_reset_rsp_idle, reset, !rsp_valid, "response beat valid right after reset")
   `FSLA_ASSERT_ALWAYS_NEXT(a_reset_req_open, reset, req_ready, "command queue not open right after reset")

endmodule

bind fixed_slot_free_list_allocator_core fsla_checker u_fsla_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_slot   (rsp_chan.slot),
   .rsp_status (rsp_chan.status)
);

`default_nettype wire
